>>> src/cdpts_pkg.sv
// Shared constants and the prime tap table of the delay block.
// No dependencies.
package cdpts_pkg;

  localparam int unsigned EchoDepthDefault = 44100;
  localparam int unsigned TapSpan = 128;
  localparam int unsigned TapStoreDepth = 2 * TapSpan + 1;
  localparam int unsigned ChaseLimit = 9000;
  localparam int unsigned MaxTaps = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_DRY = 3'd0;
  localparam logic [2:0] REG_WET = 3'd1;
  localparam logic [2:0] REG_TARGET = 3'd2;
  localparam logic [2:0] REG_FEEDBACK = 3'd3;
  localparam logic [2:0] REG_LEAN = 3'd4;
  localparam logic [2:0] REG_TAPS = 3'd5;

  // Distance of prime tap i from the write position.
  function automatic logic [6:0] prime_tap(input logic [4:0] i);
    logic [6:0] t;
    case (i)
      5'd0: t = 7'd1;    5'd1: t = 7'd2;    5'd2: t = 7'd3;    5'd3: t = 7'd5;
      5'd4: t = 7'd7;    5'd5: t = 7'd11;   5'd6: t = 7'd13;   5'd7: t = 7'd17;
      5'd8: t = 7'd19;   5'd9: t = 7'd23;   5'd10: t = 7'd29;  5'd11: t = 7'd31;
      5'd12: t = 7'd37;  5'd13: t = 7'd41;  5'd14: t = 7'd43;  5'd15: t = 7'd47;
      5'd16: t = 7'd53;  5'd17: t = 7'd59;  5'd18: t = 7'd61;  5'd19: t = 7'd67;
      5'd20: t = 7'd71;  5'd21: t = 7'd73;  5'd22: t = 7'd79;  5'd23: t = 7'd83;
      5'd24: t = 7'd89;  5'd25: t = 7'd97;  5'd26: t = 7'd101; 5'd27: t = 7'd103;
      5'd28: t = 7'd107; 5'd29: t = 7'd109; 5'd30: t = 7'd113; default: t = 7'd127;
    endcase
    return t;
  endfunction

endpackage

>>> src/cdpts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cdpts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/chasing_delay_prime_tap_smear.sv
// Mono feedback delay with a prime-spaced tap smear and a chasing length. One
// sample is accepted at a time. The sequencer reads the tap store once per tap
// through S_TAP_RD, S_TAP_WAIT and S_TAP_ACC, divides the tap total in a
// 41-step restoring divider, and steps all products through one shared 34x17
// multiplier. A finished sample waits in S_OUT until the output register is
// free or being taken. After reset a clearing pass zeroes both memories before
// the first sample is taken; write configuration only while no sample is in
// flight.
// Depends on cdpts_pkg and cdpts_ram.
module chasing_delay_prime_tap_smear #(
  parameter int unsigned EchoDepth = cdpts_pkg::EchoDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] sample_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cdpts_pkg::*;

  localparam int unsigned EAW = $clog2(EchoDepth);
  localparam int unsigned TAW = $clog2(TapStoreDepth);
  localparam logic [16:0] LenMax = 17'(EchoDepth - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_LINE, S_WAIT_LINE, S_FB_MUL, S_SUM, S_WR_LO,
    S_TAP_RD, S_TAP_WAIT, S_TAP_ACC, S_DIV, S_SCALE_MUL, S_SCALE,
    S_XF_MUL, S_STORE, S_CHASE, S_PTR, S_OUT_RD, S_OUT_WAIT, S_DRY_MUL,
    S_WET_MUL, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] dry_r, wet_r, target_r, lean_r;
  logic [14:0] fb_r;
  logic [5:0]  taps_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r <= 16'd32768; wet_r <= 16'd16384; target_r <= 16'd22000;
      fb_r <= 15'd8192; lean_r <= 16'd0; taps_cfg_r <= 6'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRY:      dry_r <= cfg_data;
        REG_WET:      wet_r <= cfg_data;
        REG_TARGET:   target_r <= cfg_data;
        REG_FEEDBACK: fb_r <= cfg_data[14:0];
        REG_LEAN:     lean_r <= cfg_data;
        REG_TAPS:     taps_cfg_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Datapath and control registers.
  logic [16:0] clr_cnt_r;
  logic [16:0] ptr_r, len_r;
  logic [7:0]  tidx_r;
  logic [15:0] chase_r;
  logic signed [23:0] x_r;
  logic signed [31:0] sum_r, store_r;
  logic signed [40:0] total_r;
  logic signed [63:0] prod_r;
  logic signed [40:0] acc_r;
  logic [5:0]  taps_r;
  logic [4:0]  tap_i_r;
  logic [41:0] rem_r;
  logic [40:0] quo_r;
  logic [5:0]  div_cnt_r;
  logic        div_neg_r;
  logic signed [47:0] avg_r;
  logic signed [47:0] scaled_r;
  logic [1:0]  wr_step_r;
  logic [23:0] out_data_r;
  logic        out_valid_r;

  // Memory ports.
  logic            ln_we, ts_we;
  logic [EAW-1:0]  ln_wa, ln_ra;
  logic [TAW-1:0]  ts_wa, ts_ra;
  logic [31:0]     ln_wd, ts_wd, ln_rd, ts_rd;

  cdpts_ram #(.Width(32), .Depth(EchoDepth)) u_line (
    .clk(clk), .wr_en(ln_we), .wr_addr(ln_wa), .wr_data(ln_wd),
    .rd_addr(ln_ra), .rd_data(ln_rd));

  cdpts_ram #(.Width(32), .Depth(TapStoreDepth)) u_taps (
    .clk(clk), .wr_en(ts_we), .wr_addr(ts_wa), .wr_data(ts_wd),
    .rd_addr(ts_ra), .rd_data(ts_rd));

  // Shared multiplier operands; the tap average needs 34 signed bits.
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [15:0] mag;
  assign mag = lean_r[15] ? 16'(-lean_r) : lean_r;
  logic [7:0] ti_c;
  assign ti_c = (tidx_r > 8'd128) ? 8'd128 : tidx_r;
  logic [16:0] tgt_c;
  assign tgt_c = (17'(target_r) > LenMax) ? LenMax : 17'(target_r);
  logic [16:0] diff_c;
  assign diff_c = (len_r > tgt_c) ? len_r - tgt_c : tgt_c - len_r;
  logic [16:0] acc_chase_c;
  assign acc_chase_c = 17'(chase_r) + diff_c;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic signed [63:0] rnd14, rnd15, prod15;
  assign rnd14 = (prod_r + 64'sd8192) >>> 14;
  assign rnd15 = (prod_r + 64'sd16384) >>> 15;
  assign prod15 = 64'(mul_p);

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 17'sd0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = store_r; ln_ra = ptr_r[EAW-1:0];
    ts_we = 1'b0; ts_wa = '0; ts_wd = sum_r;
    ts_ra = TAW'(9'(ti_c) + 9'(prime_tap(tap_i_r)));
    unique case (state_r)
      S_CLEAR: begin
        ln_we = clr_cnt_r < 17'(EchoDepth);
        ln_wa = EAW'(clr_cnt_r);
        ln_wd = '0;
        ts_we = clr_cnt_r < 17'(TapStoreDepth);
        ts_wa = TAW'(clr_cnt_r);
        ts_wd = '0;
      end
      S_FB_MUL: begin mul_a = 34'(signed'(ln_rd)); mul_b = 17'(fb_r); end
      S_WR_LO: begin
        ts_we = 1'b1; ts_wa = TAW'(ti_c);
      end
      S_TAP_RD: begin
        ts_we = 1'b1; ts_wa = TAW'(9'(ti_c) + 9'd128);
      end
      S_SCALE_MUL: begin mul_a = avg_r[33:0]; mul_b = 17'(mag); end
      S_XF_MUL: begin mul_a = 34'(sum_r); mul_b = 17'(17'd32768 - 17'(mag)); end
      // A growing step writes only the new position.
      S_CHASE: begin
        ln_we = (wr_step_r == 2'd1) || (wr_step_r == 2'd2); ln_wa = EAW'(ptr_r);
      end
      S_OUT_RD: ln_ra = EAW'(ptr_r);
      S_DRY_MUL: begin mul_a = 34'(x_r); mul_b = 17'(dry_r); end
      S_WET_MUL: begin mul_a = 34'(signed'(ln_rd)); mul_b = 17'(wet_r); end
      default: ;
    endcase
  end

  logic signed [47:0] scaled_full;
  assign scaled_full = 48'(rnd15);

  // Sequencer: state, pointers and registered output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_cnt_r <= '0; ptr_r <= '0; len_r <= '0;
      tidx_r <= '0; chase_r <= '0; out_valid_r <= 1'b0; wr_step_r <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 17'd1;
          if (clr_cnt_r >= 17'(EchoDepth) && clr_cnt_r >= 17'(TapStoreDepth))
            state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          x_r <= in_tdata;
          if (ptr_r > len_r) ptr_r <= len_r;
          taps_r <= (taps_cfg_r == 6'd0) ? 6'd1 :
                    (taps_cfg_r > 6'd32) ? 6'd32 : taps_cfg_r;
          state_r <= S_RD_LINE;
        end
        S_RD_LINE: state_r <= S_WAIT_LINE;
        S_WAIT_LINE: state_r <= S_FB_MUL;
        S_FB_MUL: begin prod_r <= mul_p; state_r <= S_SUM; end
        S_SUM: begin
          sum_r <= sat32(64'(x_r) + rnd14);
          state_r <= S_WR_LO;
        end
        S_WR_LO: begin
          total_r <= 41'(sum_r); tap_i_r <= '0; state_r <= S_TAP_RD;
        end
        S_TAP_RD: state_r <= S_TAP_WAIT;
        S_TAP_WAIT: state_r <= S_TAP_ACC;
        S_TAP_ACC: begin
          total_r <= total_r + 41'(signed'(ts_rd));
          if (6'(tap_i_r) + 6'd1 == taps_r) begin
            div_neg_r <= (total_r + 41'(signed'(ts_rd))) < 0;
            rem_r <= '0; div_cnt_r <= 6'd41; state_r <= S_DIV;
            quo_r <= (total_r + 41'(signed'(ts_rd)) < 0) ?
                     41'(-(total_r + 41'(signed'(ts_rd)))) :
                     41'(total_r + 41'(signed'(ts_rd)));
          end else begin
            tap_i_r <= tap_i_r + 5'd1; state_r <= S_TAP_RD;
          end
        end
        // Restoring division of |total| by taps, one bit a cycle.
        S_DIV: begin
          if (div_cnt_r == 6'd0) begin
            avg_r <= (div_neg_r ? -48'(quo_r) : 48'(quo_r)) + 48'sd1;
            state_r <= S_SCALE_MUL;
          end else begin
            if ({rem_r[40:0], quo_r[40]} >= 42'(taps_r)) begin
              rem_r <= {rem_r[40:0], quo_r[40]} - 42'(taps_r);
              quo_r <= {quo_r[39:0], 1'b1};
            end else begin
              rem_r <= {rem_r[40:0], quo_r[40]};
              quo_r <= {quo_r[39:0], 1'b0};
            end
            div_cnt_r <= div_cnt_r - 6'd1;
          end
        end
        S_SCALE_MUL: begin prod_r <= mul_p; state_r <= S_SCALE; end
        S_SCALE: begin
          scaled_r <= scaled_full;
          if (lean_r[15]) begin
            store_r <= sat32(64'(sum_r) - rnd15);
            state_r <= S_STORE;
          end else state_r <= S_XF_MUL;
        end
        S_XF_MUL: begin prod_r <= prod15; state_r <= S_STORE; end
        S_STORE: begin
          if (!lean_r[15]) store_r <= sat32(rnd15 + 64'(scaled_r));
          if (acc_chase_c > 17'(ChaseLimit)) begin
            chase_r <= '0;
            wr_step_r <= (len_r > tgt_c) ? 2'd2 : (len_r < tgt_c) ? 2'd3 : 2'd0;
          end else begin
            chase_r <= acc_chase_c[15:0]; wr_step_r <= 2'd1;
          end
          state_r <= S_CHASE;
        end
        // Line write unless a due chase is at target; steps move the pointer.
        S_CHASE: begin
          unique case (wr_step_r)
            2'd2: begin
              len_r <= len_r - 17'd1;
              ptr_r <= (ptr_r == 17'd0) ? len_r - 17'd1 : ptr_r - 17'd1;
              wr_step_r <= 2'd1;
            end
            2'd3: begin
              len_r <= len_r + 17'd1;
              ptr_r <= (ptr_r + 17'd1 > len_r + 17'd1) ? 17'd0 : ptr_r + 17'd1;
              wr_step_r <= 2'd1;
            end
            default: begin wr_step_r <= 2'd0; state_r <= S_PTR; end
          endcase
        end
        S_PTR: begin
          tidx_r <= ti_c - 8'd1;
          if (ptr_r == 17'd0) ptr_r <= len_r;
          else ptr_r <= ptr_r - 17'd1;
          state_r <= S_OUT_RD;
        end
        S_OUT_RD: state_r <= S_OUT_WAIT;
        S_OUT_WAIT: state_r <= S_DRY_MUL;
        S_DRY_MUL: begin prod_r <= mul_p; state_r <= S_WET_MUL; end
        S_WET_MUL: begin prod_r <= prod_r + mul_p; state_r <= S_OUT; end
        S_OUT: if (!out_valid_r || out_tready) begin
          out_data_r <= (rnd15 > 64'sd8388607) ? 24'h7FFFFF :
                        (rnd15 < -64'sd8388608) ? 24'h800000 : rnd15[23:0];
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

`ifndef SYNTH
  // Pointer does not pass the length when the output is read.
  a_ptr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_RD) |-> (ptr_r <= len_r))
    else $error("pointer beyond length");
  // Length stays inside the line.
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenMax) else $error("length beyond line");
  // No input accepted during the clearing pass.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready) else $error("ready while clearing");
`endif

endmodule
